>>> design/bns_pkg.sv
// shared constants, register codes and control structs of the beat note scheduler
`default_nettype none

package bns_pkg;

    // pending note-off table
    localparam int PENDING_SLOTS = 8;
    localparam int SLOT_W        = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;
    localparam int MAX_RESULTS   = 8;
    localparam int CNT_W         = $clog2(MAX_RESULTS + 1);

    // field widths
    localparam int NOTE_W = 7;
    localparam int CHAN_W = 5;
    localparam int VEL_W  = 7;
    localparam int LEN_W  = 20;
    localparam int BLK_W  = 16;
    localparam int SOFF_W = 17;
    localparam int STR_W  = 17;
    localparam int REM_W  = 21;
    localparam int PROD_W = 24;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NOTE_NUMBER   = 3'd0,
        REG_MIDI_CHANNEL  = 3'd1,
        REG_FIXED_VEL     = 3'd2,
        REG_VEL_MODE      = 3'd3,
        REG_NOTE_LENGTH   = 3'd4
    } t_cfg_reg;

    // register reset values
    localparam logic [NOTE_W-1:0] RST_NOTE_NUMBER = 7'd36;
    localparam logic [CHAN_W-1:0] RST_MIDI_CHAN   = 5'd10;
    localparam logic [VEL_W-1:0]  RST_FIXED_VEL   = 7'd100;
    localparam logic              RST_VEL_MODE    = 1'b0;
    localparam logic [LEN_W-1:0]  RST_NOTE_LENGTH = 20'd4410;

    // channel limits
    localparam logic [CHAN_W-1:0] CHAN_MIN = 5'd1;
    localparam logic [CHAN_W-1:0] CHAN_MAX = 5'd16;

    // velocity from strength: base + strength * gain / 2^16
    localparam logic [8:0]        VEL_BASE = 9'd25;
    localparam logic [PROD_W-1:0] VEL_GAIN = 24'd102;
    localparam logic [8:0]        VEL_MAX  = 9'd127;
    localparam logic [8:0]        VEL_MIN  = 9'd1;

    localparam logic VEL_MODE_FIXED = 1'b0;

    // codes of the item and event fields
    localparam logic ACT_BLOCK   = 1'b0;
    localparam logic ACT_TRIGGER = 1'b1;
    localparam logic EV_NOTE_ON  = 1'b0;
    localparam logic EV_NOTE_OFF = 1'b1;

    typedef struct packed {
        logic load;
        logic mask;
        logic walk_step;
        logic calc;
        logic sum;
        logic emit_on;
        logic emit_off;
        logic store;
    } t_cmd;

    typedef struct packed {
        logic in_action;
        logic out_free;
        logic walk_stall;
        logic walk_end;
        logic in_block;
    } t_stat;

endpackage

`default_nettype wire

>>> design/beat_note_scheduler.sv
// top level of the beat note scheduler: controller plus datapath
`default_nettype none

// channel      | handshake            | payload
// -------------+----------------------+-----------------------------------------------
// item in      | i_valid / o_ready    | i_action, i_block_samples, i_sample_offset,
//              |                      | i_strength
// event out    | o_valid / i_ready    | o_event_kind, o_channel, o_note, o_velocity,
//              |                      | o_event_offset, o_last
// config write | i_cfg_we             | i_cfg_index, i_cfg_data (no wait, no read-back)
//
// a trigger beat steps through accept, clamp and velocity multiply, offset add, note-on,
// note-off or slot store; a block-start beat steps through accept, mask and a slot walk
// that visits one slot a cycle unless an event waits, through a single shared subtractor
// the event register frees the datapath as soon as the consumer takes a beat; with i_ready
// low a waiting event stalls the sequence at its next emit
// synchronous active-low reset clears slot valid bits, block length and event valid at once

module beat_note_scheduler (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // configuration
    input  wire logic                               i_cfg_we,
    input  wire logic [bns_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [bns_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // item in
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic                               i_action,
    input  wire logic [bns_pkg::BLK_W-1:0]          i_block_samples,
    input  wire logic signed [bns_pkg::SOFF_W-1:0]  i_sample_offset,
    input  wire logic [bns_pkg::STR_W-1:0]          i_strength,
    // event out
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic                                    o_event_kind,
    output logic [bns_pkg::CHAN_W-1:0]              o_channel,
    output logic [bns_pkg::NOTE_W-1:0]              o_note,
    output logic [bns_pkg::VEL_W-1:0]               o_velocity,
    output logic [bns_pkg::BLK_W-1:0]               o_event_offset,
    output logic                                    o_last
);

    // commands from the sequencer, status back from the datapath
    bns_pkg::t_cmd  cmd;
    bns_pkg::t_stat stat;

    // sequencer: accepts a beat only when idle, then steps either the slot walk
    // or the trigger sequence
    bns_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // datapath: config registers, slot table, clamp and velocity logic,
    // event register
    bns_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_action        (i_action),
        .i_block_samples (i_block_samples),
        .i_sample_offset (i_sample_offset),
        .i_strength      (i_strength),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_ready         (i_ready),
        .o_valid         (o_valid),
        .o_event_kind    (o_event_kind),
        .o_channel       (o_channel),
        .o_note          (o_note),
        .o_velocity      (o_velocity),
        .o_event_offset  (o_event_offset),
        .o_last          (o_last)
    );

endmodule

`default_nettype wire

>>> design/bns_ctrl.sv
// sequencing state machine of the beat note scheduler
`default_nettype none

module bns_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire bns_pkg::t_stat i_stat,
    output bns_pkg::t_cmd      o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MASK,
        ST_WALK,
        ST_CALC,
        ST_SUM,
        ST_ON,
        ST_OFF
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = (i_stat.in_action == bns_pkg::ACT_TRIGGER) ? ST_CALC : ST_MASK;
                end
            end
            ST_MASK: begin
                o_cmd.mask = 1'b1;
                n_state = ST_WALK;
            end
            ST_WALK: begin
                if (!i_stat.walk_stall) begin
                    o_cmd.walk_step = 1'b1;
                    if (i_stat.walk_end) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_CALC: begin
                o_cmd.calc = 1'b1;
                n_state = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_state = ST_ON;
            end
            ST_ON: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_on = 1'b1;
                    n_state = ST_OFF;
                end
            end
            ST_OFF: begin
                if (!i_stat.in_block) begin
                    o_cmd.store = 1'b1;
                    n_state = ST_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.emit_off = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

>>> design/bns_datapath.sv
// registers, slot table, arithmetic and output register of the beat note scheduler
`default_nettype none

module bns_datapath (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [bns_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [bns_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  wire logic                                i_action,
    input  wire logic [bns_pkg::BLK_W-1:0]           i_block_samples,
    input  wire logic signed [bns_pkg::SOFF_W-1:0]   i_sample_offset,
    input  wire logic [bns_pkg::STR_W-1:0]           i_strength,
    input  wire bns_pkg::t_cmd                       i_cmd,
    output bns_pkg::t_stat                           o_stat,
    input  wire logic                                i_ready,
    output logic                                     o_valid,
    output logic                                     o_event_kind,
    output logic [bns_pkg::CHAN_W-1:0]               o_channel,
    output logic [bns_pkg::NOTE_W-1:0]               o_note,
    output logic [bns_pkg::VEL_W-1:0]                o_velocity,
    output logic [bns_pkg::BLK_W-1:0]                o_event_offset,
    output logic                                     o_last
);

    localparam int P = bns_pkg::PENDING_SLOTS;

    // configuration
    logic [bns_pkg::NOTE_W-1:0] r_note_number;
    logic [bns_pkg::CHAN_W-1:0] r_midi_chan;
    logic [bns_pkg::VEL_W-1:0]  r_fixed_vel;
    logic                       r_vel_mode;
    logic [bns_pkg::LEN_W-1:0]  r_note_len;

    // item state
    logic [bns_pkg::BLK_W-1:0]          r_block_len;
    logic signed [bns_pkg::SOFF_W-1:0]  r_soff;
    logic [bns_pkg::STR_W-1:0]          r_strength;
    logic [bns_pkg::BLK_W-1:0]          r_off;
    logic [bns_pkg::VEL_W-1:0]          r_vel;
    logic [bns_pkg::CHAN_W-1:0]         r_chan;
    logic [bns_pkg::NOTE_W-1:0]         r_note;
    logic [bns_pkg::REM_W-1:0]          r_offoff;
    logic                               r_in_block;

    // slot table
    logic [P-1:0]               r_slot_active;
    logic [bns_pkg::REM_W-1:0]  r_slot_rem  [P];
    logic [bns_pkg::NOTE_W-1:0] r_slot_note [P];
    logic [bns_pkg::CHAN_W-1:0] r_slot_chan [P];

    // walk
    logic [P-1:0]                r_mask;
    logic [bns_pkg::SLOT_W-1:0]  r_idx;
    logic [bns_pkg::CNT_W-1:0]   r_cnt;

    // output register
    logic                        r_out_valid;
    logic                        r_out_kind;
    logic [bns_pkg::CHAN_W-1:0]  r_out_chan;
    logic [bns_pkg::NOTE_W-1:0]  r_out_note;
    logic [bns_pkg::VEL_W-1:0]   r_out_vel;
    logic [bns_pkg::BLK_W-1:0]   r_out_off;
    logic                        r_out_last;

    logic                        out_free;
    logic [bns_pkg::REM_W-1:0]   blk_ext;
    logic [bns_pkg::BLK_W-1:0]   max_off;
    logic [bns_pkg::BLK_W-1:0]   off_clamped;
    logic [bns_pkg::CHAN_W-1:0]  chan_clamped;
    logic [bns_pkg::PROD_W-1:0]  product;
    logic [8:0]                  vel_sum;
    logic [bns_pkg::VEL_W-1:0]   vel_strength;
    logic [bns_pkg::LEN_W-1:0]   len_used;
    logic [bns_pkg::REM_W-1:0]   offoff_sum;
    logic [bns_pkg::SLOT_W-1:0]  free_slot;
    logic [P-1:0]                expire;
    logic [P-1:0]                above;
    logic                        walk_emit;
    logic                        walk_last;
    logic [bns_pkg::REM_W-1:0]   rem_cur;

    assign out_free = !r_out_valid || i_ready;
    assign blk_ext  = {{(bns_pkg::REM_W - bns_pkg::BLK_W){1'b0}}, r_block_len};

    // trigger arithmetic
    always_comb begin
        max_off = (r_block_len != '0) ? r_block_len - 1'b1 : '0;
        if (r_soff < 0) begin
            off_clamped = '0;
        end else if (r_soff[bns_pkg::BLK_W-1:0] > max_off) begin
            off_clamped = max_off;
        end else begin
            off_clamped = r_soff[bns_pkg::BLK_W-1:0];
        end

        if (r_midi_chan < bns_pkg::CHAN_MIN) begin
            chan_clamped = bns_pkg::CHAN_MIN;
        end else if (r_midi_chan > bns_pkg::CHAN_MAX) begin
            chan_clamped = bns_pkg::CHAN_MAX;
        end else begin
            chan_clamped = r_midi_chan;
        end

        product = {{(bns_pkg::PROD_W - bns_pkg::STR_W){1'b0}}, r_strength} * bns_pkg::VEL_GAIN;
        vel_sum = {1'b0, product[bns_pkg::PROD_W-1:16]} + bns_pkg::VEL_BASE;
        if (vel_sum > bns_pkg::VEL_MAX) begin
            vel_strength = bns_pkg::VEL_MAX[bns_pkg::VEL_W-1:0];
        end else if (vel_sum < bns_pkg::VEL_MIN) begin
            vel_strength = bns_pkg::VEL_MIN[bns_pkg::VEL_W-1:0];
        end else begin
            vel_strength = vel_sum[bns_pkg::VEL_W-1:0];
        end

        len_used   = (r_note_len != '0) ? r_note_len : bns_pkg::LEN_W'(1);
        offoff_sum = {{(bns_pkg::REM_W - bns_pkg::BLK_W){1'b0}}, r_off}
                   + {{(bns_pkg::REM_W - bns_pkg::LEN_W){1'b0}}, len_used};
    end

    // first free slot, slot 0 when all busy
    always_comb begin
        free_slot = '0;
        for (int i = P - 1; i >= 0; i--) begin
            if (!r_slot_active[i]) begin
                free_slot = bns_pkg::SLOT_W'(i);
            end
        end
    end

    // block walk
    always_comb begin
        for (int i = 0; i < P; i++) begin
            expire[i] = r_slot_active[i] && (r_slot_rem[i] < blk_ext);
            above[i]  = (i > int'(r_idx));
        end
        rem_cur   = r_slot_rem[r_idx];
        walk_emit = r_mask[r_idx] && (r_cnt < bns_pkg::CNT_W'(bns_pkg::MAX_RESULTS));
        walk_last = (r_cnt == bns_pkg::CNT_W'(bns_pkg::MAX_RESULTS - 1))
                 || ((r_mask & above) == '0);
    end

    always_comb begin
        o_stat            = '0;
        o_stat.in_action  = i_action;
        o_stat.out_free   = out_free;
        o_stat.walk_stall = walk_emit && !out_free;
        o_stat.walk_end   = (r_idx == bns_pkg::SLOT_W'(P - 1));
        o_stat.in_block   = r_in_block;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_note_number <= bns_pkg::RST_NOTE_NUMBER;
            r_midi_chan   <= bns_pkg::RST_MIDI_CHAN;
            r_fixed_vel   <= bns_pkg::RST_FIXED_VEL;
            r_vel_mode    <= bns_pkg::RST_VEL_MODE;
            r_note_len    <= bns_pkg::RST_NOTE_LENGTH;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bns_pkg::REG_NOTE_NUMBER:  r_note_number <= i_cfg_data[bns_pkg::NOTE_W-1:0];
                bns_pkg::REG_MIDI_CHANNEL: r_midi_chan   <= i_cfg_data[bns_pkg::CHAN_W-1:0];
                bns_pkg::REG_FIXED_VEL:    r_fixed_vel   <= i_cfg_data[bns_pkg::VEL_W-1:0];
                bns_pkg::REG_VEL_MODE:     r_vel_mode    <= i_cfg_data[0];
                bns_pkg::REG_NOTE_LENGTH:  r_note_len    <= i_cfg_data[bns_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // item registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_len <= '0;
        end else if (i_cmd.load && (i_action == bns_pkg::ACT_BLOCK)) begin
            r_block_len <= i_block_samples;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_soff     <= i_sample_offset;
            r_strength <= i_strength;
        end
        if (i_cmd.calc) begin
            r_off  <= off_clamped;
            r_vel  <= (r_vel_mode == bns_pkg::VEL_MODE_FIXED) ? r_fixed_vel : vel_strength;
            r_chan <= chan_clamped;
            r_note <= r_note_number;
        end
        if (i_cmd.sum) begin
            r_offoff   <= offoff_sum;
            r_in_block <= offoff_sum < blk_ext;
        end
    end

    // slot table and walk counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_active <= '0;
            r_idx         <= '0;
            r_cnt         <= '0;
            r_mask        <= '0;
        end else begin
            if (i_cmd.mask) begin
                r_mask <= expire;
                r_idx  <= '0;
                r_cnt  <= '0;
            end
            if (i_cmd.walk_step) begin
                r_idx <= r_idx + 1'b1;
                if (r_mask[r_idx]) begin
                    r_slot_active[r_idx] <= 1'b0;
                    if (walk_emit) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end else if (r_slot_active[r_idx]) begin
                    r_slot_rem[r_idx] <= rem_cur - blk_ext;
                end
            end
            if (i_cmd.store) begin
                r_slot_active[free_slot] <= 1'b1;
                r_slot_rem[free_slot]    <= r_offoff - blk_ext;
                r_slot_note[free_slot]   <= r_note;
                r_slot_chan[free_slot]   <= r_chan;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_on || i_cmd.emit_off || (i_cmd.walk_step && walk_emit)) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_on) begin
            r_out_kind <= bns_pkg::EV_NOTE_ON;
            r_out_chan <= r_chan;
            r_out_note <= r_note;
            r_out_vel  <= r_vel;
            r_out_off  <= r_off;
            r_out_last <= !r_in_block;
        end else if (i_cmd.emit_off) begin
            r_out_kind <= bns_pkg::EV_NOTE_OFF;
            r_out_chan <= r_chan;
            r_out_note <= r_note;
            r_out_vel  <= '0;
            r_out_off  <= r_offoff[bns_pkg::BLK_W-1:0];
            r_out_last <= 1'b1;
        end else if (i_cmd.walk_step && walk_emit) begin
            r_out_kind <= bns_pkg::EV_NOTE_OFF;
            r_out_chan <= r_slot_chan[r_idx];
            r_out_note <= r_slot_note[r_idx];
            r_out_vel  <= '0;
            r_out_off  <= rem_cur[bns_pkg::BLK_W-1:0];
            r_out_last <= walk_last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_event_kind   = r_out_kind;
    assign o_channel      = r_out_chan;
    assign o_note         = r_out_note;
    assign o_velocity     = r_out_vel;
    assign o_event_offset = r_out_off;
    assign o_last         = r_out_last;

endmodule

`default_nettype wire
